FILE: rtl/core/lts_pkg.sv
// Shared types and constants of the laxity task scheduler.
package lts_pkg;

  localparam int NTASK = 6;
  localparam logic [2:0] IDLE_TASK = 3'd6;
  localparam logic signed [31:0] PRIO_NONE = 32'sd32767;

  typedef enum logic [1:0] {
    PH_WAITING = 2'd0,
    PH_READY   = 2'd1,
    PH_RUNNING = 2'd2,
    PH_ENDED   = 2'd3
  } phase_t;

  localparam logic [1:0] FN_RELEASE  = 2'd0;
  localparam logic [1:0] FN_FINISH   = 2'd1;
  localparam logic [1:0] FN_SCHEDULE = 2'd2;

  localparam logic [2:0] REG_HALT_EN = 3'd6;

  // one task entry as held in the state memory
  typedef struct packed {
    logic [1:0]         phase;
    logic [31:0]        start_stamp;
    logic [31:0]        end_stamp;
    logic signed [11:0] base;
    logic [7:0]         fault_count;
  } task_entry_t;

  localparam int ENTRY_W = $bits(task_entry_t);

  function automatic logic signed [11:0] base_init(input logic [2:0] i);
    case (i)
      3'd0: base_init = 12'sd10;
      3'd2: base_init = -12'sd30;
      3'd4: base_init = -12'sd30;
      3'd5: base_init = -12'sd100;
      default: base_init = 12'sd0;
    endcase
  endfunction

endpackage

FILE: rtl/core/laxity_task_scheduler.sv
// Top level of the six-task least-laxity-first event scheduler.
//
// Use: event words enter on s_axis (tuser: func; tdata: task_index, now_tick
// from bit 0 up); each event yields exactly one result word on m_axis.
// The user must write budgets and halt enable on the cfg port only while
// idle; the block itself does not enforce it. Task state sits in a six-entry
// synchronous memory, read in the cycle after its address. Release and
// finish touch one entry: the result is set in ST_CHK after the ST_RD
// read; ignored and halted events answer directly from ST_IDLE. A schedule
// walks all six entries with read, check, fix, write back and compare; an
// active entry adds a restoring divider pass for its priority, and a demoted
// old runner adds a further read and check pass. Only one event is in
// flight; the result stays in an output register until m_axis_tready is
// high, and the next event is taken the cycle after that word is accepted.
// Reset: an ST_CLEAR sweep loads the reset entries (waiting, zero stamps,
// base 10,0,-30,0,-30,-100, zero faults); no event is taken during it.
// After a master fault every later event returns halted without effect.
module laxity_task_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  input  logic [39:0] s_axis_tdata,   // task_index[2:0], now_tick[34:3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // chosen_task[2:0], chosen_priority[34:3],
                                      // fault_mask[40:35], wake_request[41], halted[42]
);
  import lts_pkg::*;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_RD    = 9'b000000100,
    ST_CHK   = 9'b000001000,
    ST_DIV   = 9'b000010000,
    ST_CMP   = 9'b000100000,
    ST_FIX   = 9'b001000000,
    ST_FIX2  = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [15:0] budget [NTASK];
  logic halt_enable;

  task_entry_t mem [NTASK];
  task_entry_t rd_data;
  logic [2:0] rd_addr;
  logic mem_we;
  logic [2:0] wr_addr;
  task_entry_t wr_data;

  logic [2:0] idx;
  logic [1:0] func;
  logic [31:0] now;
  logic [2:0] running_task;
  logic halt_flag;
  task_entry_t ent;
  task_entry_t win_ent;
  logic [5:0] mask;
  logic signed [32:0] best;
  logic [2:0] next_task;
  logic out_valid;
  logic [47:0] out_data;

  // divider: |num| / b, num up to 66 bits signed
  logic [65:0] dividend;
  logic [15:0] divisor;
  logic [15:0] rem;
  logic [6:0] div_cnt;
  logic num_neg;

  logic [15:0] b_eff;
  assign b_eff = (budget[idx] == 16'd0) ? 16'd1 : budget[idx];

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // run-check values of current entry
  logic [31:0] run;
  logic signed [12:0] base_up, base_dn;
  logic [7:0] fc_inc;
  assign run = ent.end_stamp - ent.start_stamp;
  assign base_up = 13'(ent.base) + 13'sd5;
  assign base_dn = 13'(ent.base) - 13'sd5;
  assign fc_inc = (ent.fault_count == 8'd255) ? 8'd255 : ent.fault_count + 8'd1;

  // numerator = (b - elapsed)*100 + base*b
  logic [31:0] elapsed;
  logic signed [33:0] lax;
  logic signed [28:0] base_b;
  logic signed [65:0] num;
  assign elapsed = now - ent.start_stamp;
  assign lax = $signed({18'd0, b_eff}) - $signed({2'd0, elapsed});
  assign base_b = ent.base * $signed({1'b0, b_eff});
  assign num = 66'(lax) * 66'sd100 + 66'(base_b);

  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  assign rem_sh = {rem, dividend[65]};
  assign rem_sub = rem_sh - {1'b0, divisor};

  logic signed [66:0] q;
  logic signed [32:0] q_sat;
  always_comb begin
    q = num_neg ? -$signed({1'b0, dividend}) : $signed({1'b0, dividend});
    if (q < -67'sd2147483648) q_sat = -33'sd2147483648;
    else if (q > 67'sd2147483647) q_sat = 33'sd2147483647;
    else q_sat = q[32:0];
  end

  assign s_axis_tready = (state == ST_IDLE) && !out_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_data;

  always_ff @(posedge clk) begin
    mem_we <= 1'b0;
    if (rst) begin
      state <= ST_CLEAR;
      idx <= 3'd0;
      rd_addr <= 3'd0;
      out_valid <= 1'b0;
      running_task <= IDLE_TASK;
      halt_flag <= 1'b0;
      halt_enable <= 1'b1;
      for (int i = 0; i < NTASK; i++) budget[i] <= 16'd100;
    end else begin
      if (cfg_we) begin
        if (cfg_index < REG_HALT_EN) budget[cfg_index] <= cfg_data;
        else if (cfg_index == REG_HALT_EN) halt_enable <= cfg_data[0];
      end
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          mem_we <= 1'b1;
          wr_addr <= idx;
          wr_data <= '{phase: PH_WAITING, start_stamp: '0, end_stamp: '0,
                       base: base_init(idx), fault_count: '0};
          if (idx == 3'd5) begin
            idx <= 3'd0;
            state <= ST_IDLE;
          end else idx <= idx + 3'd1;
        end
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            func <= s_axis_tuser;
            now <= s_axis_tdata[34:3];
            mask <= '0;
            best <= 33'(PRIO_NONE);
            next_task <= IDLE_TASK;
            out_data <= {5'd0, halt_flag, 1'b0, 6'd0, PRIO_NONE, running_task};
            if (halt_flag) out_valid <= 1'b1;
            else begin
              case (s_axis_tuser)
                FN_RELEASE: begin
                  out_data[41] <= (running_task == IDLE_TASK);
                  if (s_axis_tdata[2:0] < IDLE_TASK) begin
                    idx <= s_axis_tdata[2:0];
                    rd_addr <= s_axis_tdata[2:0];
                    state <= ST_RD;
                  end else out_valid <= 1'b1;
                end
                FN_FINISH: begin
                  if (running_task < IDLE_TASK) begin
                    out_data[41] <= 1'b1;
                    idx <= running_task;
                    rd_addr <= running_task;
                    state <= ST_RD;
                  end else out_valid <= 1'b1;
                end
                FN_SCHEDULE: begin
                  idx <= 3'd0;
                  rd_addr <= 3'd0;
                  state <= ST_RD;
                end
                default: out_valid <= 1'b1;
              endcase
            end
          end
        end
        ST_RD: state <= ST_CHK; // memory read in flight
        ST_CHK: begin
          ent <= rd_data;
          if (wr_addr == idx && mem_we) ent <= wr_data;
          if (func == FN_RELEASE) begin
            if (rd_data.phase == PH_WAITING) begin
              mem_we <= 1'b1;
              wr_addr <= idx;
              wr_data <= rd_data;
              wr_data.phase <= PH_READY;
              wr_data.start_stamp <= now;
            end
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end else if (func == FN_FINISH) begin
            mem_we <= 1'b1;
            wr_addr <= idx;
            wr_data <= rd_data;
            wr_data.phase <= PH_ENDED;
            wr_data.end_stamp <= now;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end else state <= ST_FIX;
        end
        ST_FIX: begin
          state <= ST_FIX2;
          // run-time check of an ended task
          if (ent.phase == PH_ENDED) begin
            ent.phase <= PH_WAITING;
            if (run < 32'(b_eff[15:1])) begin
              mask[idx] <= 1'b1;
              ent.fault_count <= fc_inc;
              ent.base <= (base_up > 13'sd2047) ? 12'sd2047 : base_up[11:0];
            end else if (run > 32'(b_eff)) begin
              mask[idx] <= 1'b1;
              ent.fault_count <= fc_inc;
              if (ent.base > -12'sd100)
                ent.base <= (base_dn < -13'sd100) ? -12'sd100 : base_dn[11:0];
              else if (idx == 3'd5 && halt_enable) begin
                // master fault: keep task ended, count it, stop
                mem_we <= 1'b1;
                wr_addr <= idx;
                wr_data <= ent;
                wr_data.fault_count <= fc_inc;
                halt_flag <= 1'b1;
                out_data <= {5'd0, 1'b1, 1'b0, mask | 6'b100000, PRIO_NONE,
                             running_task};
                out_valid <= 1'b1;
                state <= ST_IDLE;
              end
            end
          end
        end
        ST_FIX2: begin
          mem_we <= 1'b1;
          wr_addr <= idx;
          wr_data <= ent;
          if (ent.phase != PH_WAITING) begin
            num_neg <= num[65];
            dividend <= num[65] ? 66'(-num) : 66'(num);
            divisor <= b_eff;
            rem <= '0;
            div_cnt <= 7'd0;
            state <= ST_DIV;
          end else state <= ST_CMP;
        end
        ST_DIV: begin
          if (rem_sub[16]) begin
            rem <= rem_sh[15:0];
            dividend <= {dividend[64:0], 1'b0};
          end else begin
            rem <= rem_sub[15:0];
            dividend <= {dividend[64:0], 1'b1};
          end
          if (div_cnt == 7'd65) state <= ST_CMP;
          div_cnt <= div_cnt + 7'd1;
        end
        ST_CMP: begin
          if (ent.phase != PH_WAITING && q_sat < best) begin
            best <= q_sat;
            next_task <= idx;
            win_ent <= ent;
          end
          if (idx == 3'd5) state <= ST_OUT;
          else begin
            idx <= idx + 3'd1;
            rd_addr <= idx + 3'd1;
            state <= ST_RD;
          end
        end
        ST_OUT: begin
          // demote old runner, promote winner, one entry per pass
          if (running_task < IDLE_TASK && running_task != next_task) begin
            idx <= running_task;
            rd_addr <= running_task;
            func <= 2'd3;
            running_task <= IDLE_TASK;
            state <= ST_RD;
          end else begin
            if (next_task < IDLE_TASK && running_task != next_task) begin
              mem_we <= 1'b1;
              wr_addr <= next_task;
              wr_data <= win_ent;
              wr_data.phase <= PH_RUNNING;
            end
            running_task <= next_task;
            out_data <= {5'd0, 1'b0, 1'b0, mask, best[31:0], next_task};
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // demote pass: entry read for func 3
      if (state == ST_CHK && func == 2'd3) begin
        state <= ST_OUT;
        if (rd_data.phase == PH_RUNNING) begin
          mem_we <= 1'b1;
          wr_addr <= idx;
          wr_data <= rd_data;
          wr_data.phase <= PH_READY;
        end
      end
    end
  end

endmodule
